// ----- hw/rtl/kmms_pkg.sv -----
// Package for the knight minimum-moves search: board constants, row vector type
// and the control and per-row structs shared by the cell chain and the top level.
// No dependencies.
package kmms_pkg;

    localparam int MAX_BOARD = 32;
    localparam int FIELD_W   = 6;
    localparam int LEVEL_W   = 10;
    localparam int ROW_W     = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
    localparam int NB_W      = $clog2(MAX_BOARD + 1);
    localparam int COORD_W   = ($clog2(MAX_BOARD) + 2 > 8) ? $clog2(MAX_BOARD) + 2 : 8;

    typedef logic [MAX_BOARD-1:0]      t_row;
    typedef logic signed [COORD_W-1:0] t_coord;

    // Knight offsets as (row, col): (+-1, +-2) come from rows one away with a
    // two-column shift, (+-2, +-1) from rows two away with a one-column shift.
    typedef struct packed {
        logic seed;   // load the first wavefront from the start square
        logic step;   // grow the wavefront by one move
    } t_cell_ctrl;

    typedef struct packed {
        logic row_ok;   // row lies on the board
        logic tgt_row;  // row holds the target and the target column is in range
        logic near1;    // row is one away from the start row
        logic near2;    // row is two away from the start row
    } t_row_info;

endpackage

// ----- hw/rtl/kmms_cell.sv -----
// One board row of the wavefront chain: visited and frontier bits for the row.
// Takes the frontier rows of the two neighbours on each side. Uses kmms_pkg.
module kmms_cell import kmms_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_ctrl      i_ctrl,
    input  t_row_info       i_info,
    input  t_row            i_col_ok,
    input  t_row            i_col_near1,
    input  t_row            i_col_near2,
    input  logic [ROW_W-1:0] i_tc,
    input  t_row            i_up2,
    input  t_row            i_up1,
    input  t_row            i_dn1,
    input  t_row            i_dn2,
    output t_row            o_front,
    output logic            o_hit,
    output logic            o_any
);

    t_row r_vis, r_front, n_vis, n_front;
    t_row moves, seed_cols, row_mask;
    logic r_hit, r_any;

    always_comb begin
        row_mask  = {MAX_BOARD{i_info.row_ok}} & i_col_ok;
        moves     = (i_up1 << 2) | (i_up1 >> 2) | (i_dn1 << 2) | (i_dn1 >> 2)
                  | (i_up2 << 1) | (i_up2 >> 1) | (i_dn2 << 1) | (i_dn2 >> 1);
        seed_cols = ({MAX_BOARD{i_info.near1}} & i_col_near2)
                  | ({MAX_BOARD{i_info.near2}} & i_col_near1);
        n_vis     = r_vis;
        n_front   = r_front;
        if (i_ctrl.seed) begin
            // overwrite both maps: this is the per-query clear
            n_front = seed_cols & row_mask;
            n_vis   = n_front;
        end else if (i_ctrl.step) begin
            n_front = moves & ~r_vis & row_mask;
            n_vis   = r_vis | n_front;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_hit   <= 1'b0;
            r_any   <= 1'b0;
        end else begin
            r_front <= n_front;
            r_hit   <= i_info.tgt_row & n_front[i_tc];
            r_any   <= |n_front;
        end
        r_vis <= n_vis;
    end

    assign o_front = r_front;
    assign o_hit   = r_hit;
    assign o_any   = r_any;

endmodule

// ----- hw/rtl/kmms_chain.sv -----
// Row of kmms_cell instances, one per board row, wired to neighbours one and
// two rows away, with the hit and non-empty flags gathered. Uses kmms_pkg.
module kmms_chain import kmms_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctrl       i_ctrl,
    input  t_row_info        i_info [MAX_BOARD],
    input  t_row             i_col_ok,
    input  t_row             i_col_near1,
    input  t_row             i_col_near2,
    input  logic [ROW_W-1:0] i_tc,
    output logic             o_hit,
    output logic             o_any
);

    // padded with two empty rows at each end of the board
    t_row                 pad [MAX_BOARD+4];
    logic [MAX_BOARD-1:0] hit_v, any_v;

    assign pad[0]           = '0;
    assign pad[1]           = '0;
    assign pad[MAX_BOARD+2] = '0;
    assign pad[MAX_BOARD+3] = '0;

    for (genvar r = 0; r < MAX_BOARD; r++) begin : g_row
        kmms_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (i_ctrl),
            .i_info      (i_info[r]),
            .i_col_ok    (i_col_ok),
            .i_col_near1 (i_col_near1),
            .i_col_near2 (i_col_near2),
            .i_tc        (i_tc),
            .i_up2       (pad[r]),
            .i_up1       (pad[r+1]),
            .i_dn1       (pad[r+3]),
            .i_dn2       (pad[r+4]),
            .o_front     (pad[r+2]),
            .o_hit       (hit_v[r]),
            .o_any       (any_v[r])
        );
    end

    assign o_hit = |hit_v;
    assign o_any = |any_v;

endmodule

// ----- hw/rtl/knight_min_moves_search_top.sv -----
// Knight minimum-moves search: breadth-first wavefront over a chain of row cells.
// A query is taken in idle, seeded in the seed state and grown in the run state until the
// target is hit or the wavefront empties; a same-square query answers from the seed state.
// One query at a time: a new query is accepted only after the last result is written;
// the wavefront grows one move per cycle.
// Reset: synchronous active low; board size returns to 32, no query in flight.
module knight_min_moves_search_top import kmms_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [5:0]  i_cfg_data,     // board_size
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // start_row, start_col, target_row, target_col
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // move_count, zero fill
    output logic        m_axis_tuser    // reached
);

    typedef enum logic [1:0] {ST_IDLE, ST_SEED, ST_RUN} t_state;

    t_state             r_state;
    logic [FIELD_W-1:0] r_board_size;
    logic [NB_W-1:0]    r_n;
    t_coord             r_sr, r_sc, r_tr, r_tc;
    logic               r_same;
    logic [LEVEL_W-1:0] r_level;
    logic               r_out_valid;
    logic [LEVEL_W-1:0] r_out_count;
    logic               r_out_reached;

    t_cell_ctrl         ctrl;
    t_row_info          info [MAX_BOARD];
    t_row               col_ok, col_near1, col_near2;
    logic               tc_on;
    logic [ROW_W-1:0]   tc_idx;
    logic               hit, any;
    logic               out_free;
    logic               out_load;

    assign out_free = !r_out_valid || m_axis_tready;

    // a result is written into the output register this cycle
    assign out_load = out_free && (((r_state == ST_SEED) && r_same)
                                || ((r_state == ST_RUN) && (hit || !any)));

    function automatic t_coord to_coord(input logic [FIELD_W-1:0] v);
        to_coord = t_coord'({{(COORD_W-FIELD_W){1'b0}}, v}) - t_coord'(1);
    endfunction

    assign tc_on  = (r_tc >= t_coord'(0)) && (r_tc < t_coord'(MAX_BOARD));
    assign tc_idx = r_tc[ROW_W-1:0];

    always_comb begin
        for (int c = 0; c < MAX_BOARD; c++) begin
            col_ok[c]    = NB_W'(c) < r_n;
            col_near1[c] = (r_sc == t_coord'(c + 1)) || (r_sc == t_coord'(c - 1));
            col_near2[c] = (r_sc == t_coord'(c + 2)) || (r_sc == t_coord'(c - 2));
        end
        for (int r = 0; r < MAX_BOARD; r++) begin
            info[r].row_ok  = NB_W'(r) < r_n;
            info[r].tgt_row = tc_on && (r_tr == t_coord'(r));
            info[r].near1   = (r_sr == t_coord'(r + 1)) || (r_sr == t_coord'(r - 1));
            info[r].near2   = (r_sr == t_coord'(r + 2)) || (r_sr == t_coord'(r - 2));
        end
        ctrl.seed = (r_state == ST_SEED) && !r_same;
        ctrl.step = (r_state == ST_RUN) && !hit && any;
    end

    kmms_chain u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_info      (info),
        .i_col_ok    (col_ok),
        .i_col_near1 (col_near1),
        .i_col_near2 (col_near2),
        .i_tc        (tc_idx),
        .o_hit       (hit),
        .o_any       (any)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_board_size <= FIELD_W'(32);
            r_out_valid  <= 1'b0;
            r_level      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_board_size <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_sr   <= to_coord(s_axis_tdata[5:0]);
                        r_sc   <= to_coord(s_axis_tdata[11:6]);
                        r_tr   <= to_coord(s_axis_tdata[17:12]);
                        r_tc   <= to_coord(s_axis_tdata[23:18]);
                        r_same <= (s_axis_tdata[5:0] == s_axis_tdata[17:12])
                               && (s_axis_tdata[11:6] == s_axis_tdata[23:18]);
                        if (int'(r_board_size) > MAX_BOARD) begin
                            r_n <= NB_W'(MAX_BOARD);
                        end else begin
                            r_n <= NB_W'(r_board_size);
                        end
                        r_state <= ST_SEED;
                    end
                end
                ST_SEED: begin
                    if (r_same) begin
                        // hold until the output register is free
                        if (out_free) begin
                            r_out_count   <= '0;
                            r_out_reached <= 1'b1;
                            r_state       <= ST_IDLE;
                        end
                    end else begin
                        r_level <= LEVEL_W'(1);
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (hit) begin
                        if (out_free) begin
                            r_out_count   <= r_level;
                            r_out_reached <= 1'b1;
                            r_state       <= ST_IDLE;
                        end
                    end else if (!any) begin
                        if (out_free) begin
                            r_out_count   <= '0;
                            r_out_reached <= 1'b0;
                            r_state       <= ST_IDLE;
                        end
                    end else begin
                        r_level <= r_level + LEVEL_W'(1);
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16-LEVEL_W){1'b0}}, r_out_count};
    assign m_axis_tuser  = r_out_reached;

endmodule

// ----- hw/rtl/kmms_checker.sv -----
// Port-level checker for knight_min_moves_search_top, attached by bind.
// Depends only on the top-level port list.
module kmms_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // an unreached target reports a zero count
    a_unreached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 16'd0))
        else $error("unreached result with non-zero count");

    // one query at a time: input closes after a transaction
    a_one_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input still open after a transaction");

    // a new result appears only as the search returns to idle
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready)
        else $error("result raised while a search is running");

endmodule

bind knight_min_moves_search_top kmms_checker u_kmms_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/knight_min_moves_search_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench for knight_min_moves_search_top: breadth-first distance predictor with a
// result scoreboard, a bursty query source and a stalling result sink.
// Depends on kmms_pkg and the RTL top level only.

typedef struct packed {
    logic [5:0] target_col;
    logic [5:0] target_row;
    logic [5:0] start_col;
    logic [5:0] start_row;
} t_knight_query;

typedef struct packed {
    logic       reached;
    logic [9:0] move_count;
} t_knight_answer;

class knight_scoreboard;
    localparam int SIDE = kmms_pkg::MAX_BOARD;

    t_knight_answer pending_answers[$];
    int unsigned    board_side = 32;
    int             errors;
    int             answers_checked;
    int             reached_count;
    int             unreachable_count;

    // Layered search from the start square; only squares on the board are entered,
    // so a start off the board still expands its on-board moves.
    function t_knight_answer min_knight_moves(t_knight_query q);
        int dr[8] = '{-1, 1, 1, -1, 2, 2, -2, -2};
        int dc[8] = '{-2, -2, 2, 2, -1, 1, -1, 1};
        int steps_to[SIDE * SIDE];
        int wave[$];
        int sr, sc, tr, tc, n, sq, r, c, x, y, k, depth;
        t_knight_answer ans;
        sr = int'(q.start_row) - 1;
        sc = int'(q.start_col) - 1;
        tr = int'(q.target_row) - 1;
        tc = int'(q.target_col) - 1;
        n = (board_side > SIDE) ? SIDE : int'(board_side);
        ans = '0;
        if (sr == tr && sc == tc) begin
            ans.reached = 1'b1;
            return ans;
        end
        foreach (steps_to[i]) steps_to[i] = -1;
        if (sr >= 0 && sr < n && sc >= 0 && sc < n)
            steps_to[sr * SIDE + sc] = 0;
        r = sr;
        c = sc;
        depth = 0;
        do begin
            for (k = 0; k < 8; k++) begin
                x = r + dr[k];
                y = c + dc[k];
                if (x >= 0 && x < n && y >= 0 && y < n && steps_to[x * SIDE + y] < 0) begin
                    steps_to[x * SIDE + y] = depth + 1;
                    wave.push_back(x * SIDE + y);
                end
            end
            if (wave.size() == 0)
                return ans;
            sq = wave.pop_front();
            r = sq / SIDE;
            c = sq % SIDE;
            depth = steps_to[sq];
        end while (!(r == tr && c == tc));
        ans.move_count = depth[9:0];
        ans.reached = 1'b1;
        return ans;
    endfunction

    function void note_query(t_knight_query q);
        pending_answers.push_back(min_knight_moves(q));
    endfunction

    function void check_result(logic [15:0] data, logic user);
        t_knight_answer want;
        if (pending_answers.size() == 0) begin
            errors++;
            $error("result with no query pending: move_count %0d reached %0b",
                   data[9:0], user);
            return;
        end
        want = pending_answers.pop_front();
        answers_checked++;
        if (want.reached)
            reached_count++;
        else
            unreachable_count++;
        if (data[9:0] !== want.move_count) begin
            errors++;
            $error("move_count: expected %0d, got %0d", want.move_count, data[9:0]);
        end
        if (data[15:10] !== 6'd0) begin
            errors++;
            $error("tdata fill: expected 0, got %0h", data[15:10]);
        end
        if (user !== want.reached) begin
            errors++;
            $error("reached: expected %0b, got %0b", want.reached, user);
        end
    endfunction
endclass

module knight_min_moves_search_top_tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [5:0]  i_cfg_data = 6'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // start_row, start_col, target_row, target_col
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // move_count, zero fill
    logic        m_axis_tuser;        // reached

    knight_scoreboard sb;
    int unsigned      burst_left;

    always #5 i_clk = ~i_clk;

    knight_min_moves_search_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // Offer one query; start a new burst, after a random gap, once the last one is spent.
    task automatic send_query(input t_knight_query q);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 15);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= q;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_query(q);
        burst_left--;
        @(negedge i_clk);
    endtask

    task automatic wait_for_drain();
        while (sb.pending_answers.size() != 0) @(posedge i_clk);
    endtask

    // Result sink: stall modes of random length, and one long hold-off to back up the block.
    initial begin : result_sink
        int unsigned mode;
        int unsigned mode_left;
        bit          held;
        mode_left = 0;
        held = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!held && sb.answers_checked >= 300) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                2: m_axis_tready <= ($urandom_range(0, 1) != 0);
                default: m_axis_tready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    initial begin : stimulus
        // start_row, start_col, target_row, target_col on the 32-square reset board
        int directed_sq[22][4] = '{
            '{1, 1, 1, 1},    '{0, 0, 0, 0},    '{63, 63, 63, 63}, '{10, 20, 10, 20},
            '{1, 1, 2, 3},    '{1, 2, 1, 3},    '{1, 1, 32, 32},   '{32, 32, 1, 1},
            '{1, 1, 2, 2},    '{16, 16, 17, 17}, '{32, 1, 1, 32},  '{1, 32, 32, 1},
            '{0, 5, 2, 6},    '{5, 0, 6, 2},    '{33, 33, 31, 32}, '{63, 63, 1, 1},
            '{1, 1, 0, 3},    '{1, 1, 3, 33},   '{1, 1, 63, 63},   '{5, 5, 3, 4},
            '{42, 21, 21, 42}, '{21, 42, 42, 21}
        };
        int unsigned board_plan[15] = '{1, 0, 63, 2, 3, 4, 5, 8, 33, 17, 31, 32, 12, 3, 32};
        t_knight_query q;
        int unsigned   span;
        int unsigned   pick;
        sb = new();
        burst_left = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_sq[i]) begin
            q.start_row  = 6'(directed_sq[i][0]);
            q.start_col  = 6'(directed_sq[i][1]);
            q.target_row = 6'(directed_sq[i][2]);
            q.target_col = 6'(directed_sq[i][3]);
            send_query(q);
        end
        s_axis_tvalid <= 1'b0;

        foreach (board_plan[p]) begin
            // change the board only with nothing in flight
            wait_for_drain();
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_data  <= board_plan[p][5:0];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.board_side = board_plan[p];
            @(negedge i_clk);
            i_cfg_valid <= 1'b0;
            burst_left = 0;

            span = (board_plan[p] > 32) ? 32 : board_plan[p];
            if (span == 0)
                span = 1;
            repeat (122) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    q.start_row  = 6'($urandom_range(1, span));
                    q.start_col  = 6'($urandom_range(1, span));
                    q.target_row = 6'($urandom_range(1, span));
                    q.target_col = 6'($urandom_range(1, span));
                end else if (pick < 80) begin
                    q.start_row  = 6'($urandom_range(0, 63));
                    q.start_col  = 6'($urandom_range(0, 63));
                    q.target_row = q.start_row;
                    q.target_col = q.start_col;
                end else begin
                    q = 24'($urandom_range(0, 24'hFFFFFF));
                end
                send_query(q);
            end
            s_axis_tvalid <= 1'b0;
        end

        wait_for_drain();
        repeat (40) @(posedge i_clk);
        if (sb.pending_answers.size() != 0) begin
            sb.errors++;
            $error("%0d expected results never arrived", sb.pending_answers.size());
        end
        $display("%0d queries checked across %0d board sizes", sb.answers_checked,
                 $size(board_plan) + 1);
        $display("%0d targets reached, %0d unreachable", sb.reached_count,
                 sb.unreachable_count);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("simulation failed");
        $finish;
    end
endmodule

// ----- knight_min_moves_search_top.f -----
hw/rtl/kmms_pkg.sv
hw/rtl/kmms_cell.sv
hw/rtl/kmms_chain.sv
hw/rtl/knight_min_moves_search_top.sv
hw/rtl/kmms_checker.sv
tb/knight_min_moves_search_top_tb.sv
